/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/apsd_pkg.sv */
// ----------------------------------------------------------------------------
// apsd_pkg
// types and constants shared by the pulse symbol decoder modules
// ----------------------------------------------------------------------------
package apsd_pkg;

    localparam int SYMBOL_W     = 32;
    localparam int DUR_W        = 15;
    localparam int LIMIT_W      = 12;
    localparam int BITS_PER_LED = 24;
    localparam int GATHER_W     = 5;
    localparam int CHANNEL_W    = 8;
    localparam int OUT_DATA_W   = 40;
    localparam int CFG_DATA_W   = 15;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DUR_W-1:0]   THRESHOLD_RESET = DUR_W'(8);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(41);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_WIDTH_THRESHOLD = 1'b0,
        CFG_LED_LIMIT       = 1'b1
    } cfg_index_t;

    // classified symbol passed from the front to the back
    typedef struct packed {
        logic last;
        logic bit_one;
    } sym_t;

    // frame position of the bit assembler
    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_RUN    = 3'b100
    } pos_t;

endpackage

/* rtl/apsd_front.sv */
// ----------------------------------------------------------------------------
// apsd_front
// accepts pulse symbols, measures the width and classifies it as a bit
// ----------------------------------------------------------------------------
module apsd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [apsd_pkg::DUR_W-1:0]    width_threshold,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [apsd_pkg::SYMBOL_W-1:0] in_word,
    input  logic                          in_last,
    output logic                          sym_valid,
    input  logic                          sym_ready,
    output apsd_pkg::sym_t                sym
);
    import apsd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    sym_t              sym_reg;
    logic [DUR_W-1:0]  width;

    // level0 high selects duration1, else duration0
    assign width    = in_word[DUR_W] ? in_word[SYMBOL_W-2:DUR_W+1] : in_word[DUR_W-1:0];
    assign in_ready = !valid_reg || sym_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sym_reg.bit_one <= (width < width_threshold);
            sym_reg.last    <= in_last;
        end
    end

    assign sym_valid = valid_reg;
    assign sym       = sym_reg;

endmodule

/* rtl/apsd_queue.sv */
// ----------------------------------------------------------------------------
// apsd_queue
// short fifo of classified symbols between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apsd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  apsd_pkg::sym_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output apsd_pkg::sym_t pop_data
);
    import apsd_pkg::*;

    sym_t                   mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg;
    logic [QUEUE_CNT_W-1:0] cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_NEXT(a_cnt_track, do_push && !do_pop, cnt_reg == $past(cnt_reg) + QUEUE_CNT_W'(1), "queue count missed a push")
    `ASSERT_NEXT(a_ptr_gap, do_pop && !do_push, cnt_reg == $past(cnt_reg) - QUEUE_CNT_W'(1), "queue count missed a pop")

endmodule

/* rtl/apsd_back.sv */
// ----------------------------------------------------------------------------
// apsd_back
// assembles decoded bits into grb colours and drives the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apsd_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [apsd_pkg::LIMIT_W-1:0]     led_limit,
    input  logic                             sym_valid,
    output logic                             sym_ready,
    input  apsd_pkg::sym_t                   sym,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic                             res_led_valid,
    output logic [apsd_pkg::CHANNEL_W-1:0]   res_green,
    output logic [apsd_pkg::CHANNEL_W-1:0]   res_red,
    output logic [apsd_pkg::CHANNEL_W-1:0]   res_blue,
    output logic                             res_frame_end,
    output logic [apsd_pkg::LIMIT_W-1:0]     res_leds
);
    import apsd_pkg::*;

    pos_t                    pos_reg;
    pos_t                    pos_next;
    logic                    held_reg;
    logic                    held_next;
    logic [BITS_PER_LED-1:0] shift_reg;
    logic [BITS_PER_LED-1:0] shift_next;
    logic [GATHER_W-1:0]     gathered_reg;
    logic [GATHER_W-1:0]     gathered_next;
    logic [LIMIT_W-1:0]      leds_reg;
    logic [LIMIT_W-1:0]      leds_next;
    logic [LIMIT_W-1:0]      leds_upd;
    logic [BITS_PER_LED-1:0] colour;
    logic                    done;
    logic                    take;
    logic                    emit;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_led_valid_reg;
    logic [BITS_PER_LED-1:0] out_colour_reg;
    logic                    out_frame_end_reg;
    logic [LIMIT_W-1:0]      out_leds_reg;

    assign sym_ready = !out_valid_reg || res_ready;
    assign take      = sym_valid && sym_ready;
    assign emit      = take && (done || sym.last);

    always_comb
    begin
        pos_next      = pos_reg;
        held_next     = held_reg;
        shift_next    = shift_reg;
        gathered_next = gathered_reg;
        leds_upd      = leds_reg;
        colour        = '0;
        done          = 1'b0;
        if (take)
        begin
            unique case (pos_reg)
                POS_FIRST:
                begin
                    held_next = sym.bit_one;
                    pos_next  = POS_SECOND;
                end
                POS_SECOND:
                begin
                    // a leading one followed by a zero is a stray first symbol
                    if (leds_reg < led_limit)
                    begin
                        if (held_reg && !sym.bit_one)
                        begin
                            shift_next    = {shift_reg[BITS_PER_LED-2:0], sym.bit_one};
                            gathered_next = gathered_reg + GATHER_W'(1);
                        end
                        else
                        begin
                            shift_next    = {shift_reg[BITS_PER_LED-3:0], held_reg, sym.bit_one};
                            gathered_next = gathered_reg + GATHER_W'(2);
                        end
                    end
                    pos_next = POS_RUN;
                end
                POS_RUN:
                begin
                    if (leds_reg < led_limit)
                    begin
                        if (gathered_reg == GATHER_W'(BITS_PER_LED - 1))
                        begin
                            done          = 1'b1;
                            colour        = {shift_reg[BITS_PER_LED-2:0], sym.bit_one};
                            leds_upd      = leds_reg + LIMIT_W'(1);
                            shift_next    = '0;
                            gathered_next = '0;
                        end
                        else
                        begin
                            shift_next    = {shift_reg[BITS_PER_LED-2:0], sym.bit_one};
                            gathered_next = gathered_reg + GATHER_W'(1);
                        end
                    end
                end
                default:
                begin
                    pos_next = POS_FIRST;
                end
            endcase
        end
        leds_next = leds_upd;
        if (take && sym.last)
        begin
            pos_next      = POS_FIRST;
            held_next     = 1'b0;
            shift_next    = '0;
            gathered_next = '0;
            leds_next     = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_FIRST;
            held_reg      <= 1'b0;
            shift_reg     <= '0;
            gathered_reg  <= '0;
            leds_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            shift_reg     <= shift_next;
            gathered_reg  <= gathered_next;
            leds_reg      <= leds_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_led_valid_reg <= done;
            out_colour_reg    <= colour;
            out_frame_end_reg <= sym.last;
            out_leds_reg      <= leds_upd;
        end
    end

    assign res_valid     = out_valid_reg;
    assign res_led_valid = out_led_valid_reg;
    assign res_green     = out_colour_reg[3*CHANNEL_W-1:2*CHANNEL_W];
    assign res_red       = out_colour_reg[2*CHANNEL_W-1:CHANNEL_W];
    assign res_blue      = out_colour_reg[CHANNEL_W-1:0];
    assign res_frame_end = out_frame_end_reg;
    assign res_leds      = out_leds_reg;

    `ASSERT_ALWAYS(a_gather_bound, gathered_reg < GATHER_W'(BITS_PER_LED), "bit count past one led")
    `ASSERT_NEXT(a_frame_clear, take && sym.last, pos_reg == POS_FIRST && leds_reg == '0 && gathered_reg == '0, "frame end did not clear state")
    `ASSERT_NEXT(a_emit_shown, emit, res_valid, "result lost after emit")

endmodule

/* rtl/argb_pulse_symbol_decoder_unit.sv */
// ----------------------------------------------------------------------------
// argb_pulse_symbol_decoder_unit
// decodes captured led pulse symbols into grb colours per frame
// ----------------------------------------------------------------------------
// a symbol passes the front register, the queue and the result register to reach m_tdata
// throughput: one symbol per cycle unless m_tready stalls the result register
// a stalled result register holds back the back first, the 2-entry queue absorbs the rest
// reset: rst_n clears frame state, queue and valids at once; registers to 8 and 41
// ----------------------------------------------------------------------------
module argb_pulse_symbol_decoder_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // symbol stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [apsd_pkg::SYMBOL_W-1:0]     s_tdata,   // symbol_word[31:0]
    input  logic                              s_tlast,   // frame_last
    // colour stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [apsd_pkg::OUT_DATA_W-1:0]   m_tdata,   // green[7:0], red[15:8],
                                                         // blue[23:16], leds_decoded[35:24],
                                                         // zero[39:36]
    output logic                              m_tuser,   // led_valid
    output logic                              m_tlast,   // frame_end
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  apsd_pkg::cfg_index_t              cfg_index,
    input  logic [apsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import apsd_pkg::*;

    // configuration registers
    logic [DUR_W-1:0]   threshold_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // front to queue, queue to back
    logic     f_valid;
    logic     f_ready;
    sym_t     f_sym;
    logic     q_valid;
    logic     q_ready;
    sym_t     q_sym;

    // result fields from the back
    logic                 r_led_valid;
    logic [CHANNEL_W-1:0] r_green;
    logic [CHANNEL_W-1:0] r_red;
    logic [CHANNEL_W-1:0] r_blue;
    logic [LIMIT_W-1:0]   r_leds;

    // configuration is taken every cycle; user must write only while idle, not enforced
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH_THRESHOLD: threshold_reg <= cfg_data[DUR_W-1:0];
                CFG_LED_LIMIT:       limit_reg     <= cfg_data[LIMIT_W-1:0];
                default:             threshold_reg <= threshold_reg;
            endcase
        end
    end

    // front: width measure and threshold compare, one register stage
    apsd_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .width_threshold (threshold_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_word         (s_tdata),
        .in_last         (s_tlast),
        .sym_valid       (f_valid),
        .sym_ready       (f_ready),
        .sym             (f_sym)
    );

    // decoupling queue so front and back stall independently
    apsd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_sym),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_sym)
    );

    // back: frame position, bit shifting, led count, result register
    apsd_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .led_limit     (limit_reg),
        .sym_valid     (q_valid),
        .sym_ready     (q_ready),
        .sym           (q_sym),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .res_led_valid (r_led_valid),
        .res_green     (r_green),
        .res_red       (r_red),
        .res_blue      (r_blue),
        .res_frame_end (m_tlast),
        .res_leds      (r_leds)
    );

    // pack the result transaction, green in the lowest byte
    assign m_tuser = r_led_valid;
    assign m_tdata = {(OUT_DATA_W - LIMIT_W - 3*CHANNEL_W)'(0), r_leds, r_blue, r_red, r_green};

endmodule

/* verif/tb_argb_pulse_symbol_decoder_unit.sv */
// ----------------------------------------------------------------------------
// tb_argb_pulse_symbol_decoder_unit
// self-checking bench for the led pulse symbol decoder
// ----------------------------------------------------------------------------
// a short table of hand-picked symbols runs first, then random frames under a
// series of register settings; every symbol transaction updates a local model
// of the decoder, and the colour stream is checked in order, field by field,
// while, in all but two register settings, both stream sides idle at random
// ----------------------------------------------------------------------------
module tb_argb_pulse_symbol_decoder_unit;

    import apsd_pkg::*;

    localparam int RANDOM_SYMBOLS = 650;
    localparam int NUM_SETTINGS   = 7;
    localparam int SETTLE_CYCLES  = 8;     // extra wait once no colour is owed
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    // one colour stream transaction as the decoder should present it
    typedef struct packed {
        logic                 led_valid;
        logic [CHANNEL_W-1:0] green;
        logic [CHANNEL_W-1:0] red;
        logic [CHANNEL_W-1:0] blue;
        logic                 frame_end;
        logic [LIMIT_W-1:0]   leds_decoded;
    } colour_txn_t;

    // directed stimulus row; pinned rows carry a hand-written expectation
    typedef struct {
        logic [SYMBOL_W-1:0] word;
        logic                last;
        logic                pinned;
        colour_txn_t         want;
    } symbol_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SYMBOL_W-1:0]    s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_index_t             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    argb_pulse_symbol_decoder_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirrored registers and frame state of the decoder
    logic [DUR_W-1:0]        thr_q     = THRESHOLD_RESET;
    logic [LIMIT_W-1:0]      limit_q   = LIMIT_RESET;
    pos_t                    frame_pos = POS_FIRST;
    logic                    first_bit = 1'b0;
    logic [BITS_PER_LED-1:0] grb_shift = '0;
    logic [GATHER_W-1:0]     bit_count = '0;
    logic [LIMIT_W-1:0]      led_count = '0;
    logic [BITS_PER_LED-1:0] last_grb  = '0;

    // colour transactions still owed by the decoder, oldest first
    colour_txn_t colour_q[$];
    symbol_row_t dir_rows[$];

    int errors       = 0;
    int symbols_sent = 0;
    int frames_sent  = 0;
    int colours_seen = 0;
    int leds_seen    = 0;
    int frame_left   = 0;
    int idle_cycles  = 0;
    bit gaps_on      = 1'b1;   // random idling on both stream sides

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------

    // shift one decoded bit into the current led, true when the led completes
    function automatic bit shift_in_bit(input logic b);
        if (led_count >= limit_q)
            return 1'b0;   // limit reached, bits are dropped until frame end
        grb_shift = {grb_shift[BITS_PER_LED-2:0], b};
        bit_count = bit_count + 1'b1;
        if (bit_count >= GATHER_W'(BITS_PER_LED))
        begin
            last_grb  = grb_shift;
            led_count = led_count + 1'b1;
            bit_count = '0;
            grb_shift = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // classify one symbol and advance the frame, true when a colour is owed
    function automatic bit decode_symbol(input logic [SYMBOL_W-1:0] word, input logic last,
                                         output colour_txn_t txn);
        logic [DUR_W-1:0] width;
        logic             b;
        bit               done;
        // level0 high means the low phase comes second and carries the data
        width = word[15] ? word[30:16] : word[14:0];
        b     = (width < thr_q);
        done  = 1'b0;
        case (frame_pos)
            POS_FIRST:
            begin
                first_bit = b;
                frame_pos = POS_SECOND;
            end
            POS_SECOND:
            begin
                // a one followed by a zero at frame start is a stray edge
                if (!(first_bit && !b))
                    done = shift_in_bit(first_bit);
                if (shift_in_bit(b))
                    done = 1'b1;
                frame_pos = POS_RUN;
            end
            default:
                done = shift_in_bit(b);
        endcase
        txn              = '0;
        txn.led_valid    = done;
        txn.green        = done ? last_grb[23:16] : '0;
        txn.red          = done ? last_grb[15:8]  : '0;
        txn.blue         = done ? last_grb[7:0]   : '0;
        txn.frame_end    = last;
        txn.leds_decoded = led_count;
        if (last)
        begin
            frame_pos = POS_FIRST;
            first_bit = 1'b0;
            grb_shift = '0;
            bit_count = '0;
            led_count = '0;
        end
        return done || last;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [SYMBOL_W-1:0] pack_symbol(input logic lvl1,
        input logic [DUR_W-1:0] dur1, input logic lvl0, input logic [DUR_W-1:0] dur0);
        return {lvl1, dur1, lvl0, dur0};
    endfunction

    // directed encoding: walks the data through both duration fields, with
    // the unused duration set to the opposite extreme
    function automatic logic [SYMBOL_W-1:0] encode_bit(input logic b, input int i);
        logic [DUR_W-1:0] width;
        logic [DUR_W-1:0] other;
        logic             lvl1;
        width = b ? DUR_W'(i % 8) : DUR_W'(8 + i * 1400);
        other = b ? DUR_MAX : '0;
        lvl1  = i[1];
        return i[0] ? pack_symbol(lvl1, width, 1'b1, other) : pack_symbol(lvl1, other, 1'b0, width);
    endfunction

    // random symbol aimed at one side of the threshold, with some plain noise
    function automatic logic [SYMBOL_W-1:0] random_symbol();
        logic             b;
        logic [DUR_W-1:0] width;
        logic [DUR_W-1:0] other;
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        b = 1'($urandom_range(0, 1));
        if (thr_q == 0)
            b = 1'b0;
        if (b)
            width = ($urandom_range(0, 3) == 0) ? thr_q - 1'b1 : DUR_W'($urandom_range(0, thr_q - 1));
        else
            width = ($urandom_range(0, 3) == 0) ? thr_q : DUR_W'($urandom_range(thr_q, DUR_MAX));
        other = DUR_W'($urandom());
        if ($urandom_range(0, 1))
            return pack_symbol(1'($urandom()), width, 1'b1, other);
        return pack_symbol(1'($urandom()), other, 1'b0, width);
    endfunction

    // whole leds plus a few spare bits, random lengths, and some tiny frames
    function automatic int pick_frame_length();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 2;
            2:       return 3;
            3, 4:    return 24 + $urandom_range(0, 2);
            5:       return 48 + $urandom_range(0, 3);
            6:       return 72 + $urandom_range(0, 2);
            default: return $urandom_range(4, 60);
        endcase
    endfunction

    // one symbol transaction; the model runs at the accepting edge
    task automatic send_symbol(input logic [SYMBOL_W-1:0] word, input logic last,
                               input logic pinned, input colour_txn_t want);
        int          gap;
        colour_txn_t txn;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        if (decode_symbol(word, last, txn) || pinned)
            colour_q.push_back(pinned ? want : txn);
        symbols_sent++;
        if (last)
            frames_sent++;
    endtask

    task automatic send_random();
        if (frame_left == 0)
            frame_left = pick_frame_length();
        send_symbol(random_symbol(), frame_left == 1, 1'b0, '0);
        frame_left--;
    endtask

    // hold off the sender until every owed colour is out, then let the pipe empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (colour_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_valid after the last write of a group
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WIDTH_THRESHOLD)
            thr_q = value[DUR_W-1:0];
        else
            limit_q = value[LIMIT_W-1:0];
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // colour stream sink: while gaps are on, a random stall before each transaction
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 6) : 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // colour stream checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        colour_txn_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (colour_q.size() == 0)
            begin
                $error("colour transaction with nothing owed: tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                want = colour_q.pop_front();
                // tdata: green, red, blue, leds_decoded from bit 0 up
                check_field("led_valid", 16'(want.led_valid), 16'(m_tuser));
                check_field("green", 16'(want.green), 16'(m_tdata[7:0]));
                check_field("red", 16'(want.red), 16'(m_tdata[15:8]));
                check_field("blue", 16'(want.blue), 16'(m_tdata[23:16]));
                check_field("frame_end", 16'(want.frame_end), 16'(m_tlast));
                check_field("leds_decoded", 16'(want.leds_decoded), 16'(m_tdata[35:24]));
                colours_seen++;
                if (want.led_valid)
                    leds_seen++;
            end
        end
    end

    // watchdog: any transaction on any channel counts as progress
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        colour_txn_t             frame_only;
        colour_txn_t             led_frame;
        logic [BITS_PER_LED-1:0] pattern;
        logic [DUR_W-1:0]        thr_plan [NUM_SETTINGS];
        logic [LIMIT_W-1:0]      lim_plan [NUM_SETTINGS];

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_WIDTH_THRESHOLD;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // frame end with nothing decoded: zero colour, count zero
        frame_only           = '0;
        frame_only.frame_end = 1'b1;
        // full green/red/blue led completed by the frame's last symbol
        pattern   = 24'h5AC3F0;
        led_frame = {1'b1, 8'h5A, 8'hC3, 8'hF0, 1'b1, 12'd1};

        // single-symbol frame, width zero decodes as one
        dir_rows.push_back('{pack_symbol(1'b0, DUR_MAX, 1'b0, '0), 1'b1, 1'b1, frame_only});
        // two-symbol frame: one (width just under threshold, level0 high)
        // then zero (width at threshold), so the leading one is dropped
        dir_rows.push_back('{pack_symbol(1'b0, 15'd7, 1'b1, DUR_MAX), 1'b0, 1'b0, '0});
        dir_rows.push_back('{pack_symbol(1'b1, DUR_MAX, 1'b0, 15'd8), 1'b1, 1'b1, frame_only});
        // led frame opening with the all-ones and all-zeros words
        dir_rows.push_back('{32'hFFFF_FFFF, 1'b0, 1'b0, '0});
        dir_rows.push_back('{32'h0000_0000, 1'b0, 1'b0, '0});
        for (int i = 2; i < BITS_PER_LED; i++)
            dir_rows.push_back('{encode_bit(pattern[BITS_PER_LED-1-i], i),
                                 i == BITS_PER_LED - 1, i == BITS_PER_LED - 1, led_frame});

        foreach (dir_rows[k])
            send_symbol(dir_rows[k].word, dir_rows[k].last, dir_rows[k].pinned, dir_rows[k].want);

        // register settings: reset values, extremes, a zero limit, a random one
        thr_plan = '{15'd8, 15'd0, 15'd32767, 15'd100, 15'd1, 15'd0, 15'd16384};
        lim_plan = '{12'd41, 12'd4095, 12'd1, 12'd0, 12'd2, 12'd0, 12'd41};
        thr_plan[5] = DUR_W'($urandom_range(1, DUR_MAX));
        lim_plan[5] = LIMIT_W'($urandom_range(1, 4));

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            // registers change only with the decoder empty; frames may span a write
            wait_idle();
            write_reg(CFG_WIDTH_THRESHOLD, thr_plan[p]);
            write_reg(CFG_LED_LIMIT, CFG_DATA_W'(lim_plan[p]));
            cfg_valid <= 1'b0;
            // two settings run with both stream sides at full rate
            gaps_on = (p != 1 && p != 4);
            for (int n = 0; n < RANDOM_SYMBOLS / NUM_SETTINGS; n++)
                send_random();
        end

        wait_idle();
        if (colour_q.size() != 0)
        begin
            $error("%0d colour transactions never arrived", colour_q.size());
            errors++;
        end
        $display("covered %0d symbols in %0d frames over %0d register settings",
                 symbols_sent, frames_sent, NUM_SETTINGS);
        $display("checked %0d colour transactions, %0d of them with a completed led",
                 colours_seen, leds_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
